@@ design/nrth_pkg.sv @@
// nrth_pkg: shared types, constants and the product schedule of the
// nearest ray-triangle hit block; no dependencies
`timescale 1ns / 1ps
package nrth_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int ACC_W   = 3 * COORD_W + 24;
	localparam int DIST_W  = 32;
	localparam int T_SHIFT = 16;
	localparam int STEP_W  = 5;
	localparam int SEL_W   = 4;
	localparam int REG_W   = 3;
	localparam int NUM_NAR = 12;
	localparam int NUM_WIDE = 10;

	localparam logic [REG_W-1:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [REG_W-1:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [REG_W-1:0] REG_ORIGIN_Z    = 3'd2;
	localparam logic [REG_W-1:0] REG_DIRECTION_X = 3'd3;
	localparam logic [REG_W-1:0] REG_DIRECTION_Y = 3'd4;
	localparam logic [REG_W-1:0] REG_DIRECTION_Z = 3'd5;
	localparam logic [REG_W-1:0] REG_START_RANGE = 3'd6;

	// narrow operand pool
	localparam logic [SEL_W-1:0] N_D0  = 4'd0;
	localparam logic [SEL_W-1:0] N_D1  = 4'd1;
	localparam logic [SEL_W-1:0] N_D2  = 4'd2;
	localparam logic [SEL_W-1:0] N_E1X = 4'd3;
	localparam logic [SEL_W-1:0] N_E1Y = 4'd4;
	localparam logic [SEL_W-1:0] N_E1Z = 4'd5;
	localparam logic [SEL_W-1:0] N_E2X = 4'd6;
	localparam logic [SEL_W-1:0] N_E2Y = 4'd7;
	localparam logic [SEL_W-1:0] N_E2Z = 4'd8;
	localparam logic [SEL_W-1:0] N_S0  = 4'd9;
	localparam logic [SEL_W-1:0] N_S1  = 4'd10;
	localparam logic [SEL_W-1:0] N_S2  = 4'd11;

	// wide register file
	localparam logic [SEL_W-1:0] W_H0 = 4'd0;
	localparam logic [SEL_W-1:0] W_H1 = 4'd1;
	localparam logic [SEL_W-1:0] W_H2 = 4'd2;
	localparam logic [SEL_W-1:0] W_Q0 = 4'd3;
	localparam logic [SEL_W-1:0] W_Q1 = 4'd4;
	localparam logic [SEL_W-1:0] W_Q2 = 4'd5;
	localparam logic [SEL_W-1:0] W_A  = 4'd6;
	localparam logic [SEL_W-1:0] W_SH = 4'd7;
	localparam logic [SEL_W-1:0] W_DQ = 4'd8;
	localparam logic [SEL_W-1:0] W_EQ = 4'd9;

	localparam logic [STEP_W-1:0] STEP_FLIP = 5'd15;
	localparam logic [STEP_W-1:0] STEP_END  = 5'd23;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex0_x;
		logic signed [COORD_W-1:0] vertex0_y;
		logic signed [COORD_W-1:0] vertex0_z;
		logic signed [COORD_W-1:0] vertex1_x;
		logic signed [COORD_W-1:0] vertex1_y;
		logic signed [COORD_W-1:0] vertex1_z;
		logic signed [COORD_W-1:0] vertex2_x;
		logic signed [COORD_W-1:0] vertex2_y;
		logic signed [COORD_W-1:0] vertex2_z;
		logic                      first_of_query;
		logic                      last_of_query;
	} nrth_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] nearest_distance;
		logic              hit_found;
	} nrth_out_t;

	typedef struct packed {
		logic [SEL_W-1:0] xsel;
		logic             ywide;
		logic [SEL_W-1:0] ysel;
		logic             neg;
		logic             first;
		logic             last;
		logic [SEL_W-1:0] dest;
	} nrth_uop_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic neg;
	} nrth_mac_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_WB,
		ST_CHK1,
		ST_CHK2,
		ST_DIV,
		ST_UPD,
		ST_OUT
	} nrth_state_t;

	function automatic nrth_uop_t mk(input logic [SEL_W-1:0] x, input logic yw,
		input logic [SEL_W-1:0] y, input logic n, input logic f, input logic l,
		input logic [SEL_W-1:0] d);
		nrth_uop_t u;
		u.xsel = x; u.ywide = yw; u.ysel = y; u.neg = n;
		u.first = f; u.last = l; u.dest = d;
		return u;
	endfunction

	// h = dir x e2, q = s x e1, then a, s.h, dir.q, e2.q
	function automatic nrth_uop_t nrth_uop(input logic [STEP_W-1:0] step);
		nrth_uop_t u;
		unique case (step)
			5'd0:  u = mk(N_D1,  1'b0, N_E2Z, 1'b0, 1'b1, 1'b0, W_H0);
			5'd1:  u = mk(N_D2,  1'b0, N_E2Y, 1'b1, 1'b0, 1'b1, W_H0);
			5'd2:  u = mk(N_D2,  1'b0, N_E2X, 1'b0, 1'b1, 1'b0, W_H1);
			5'd3:  u = mk(N_D0,  1'b0, N_E2Z, 1'b1, 1'b0, 1'b1, W_H1);
			5'd4:  u = mk(N_D0,  1'b0, N_E2Y, 1'b0, 1'b1, 1'b0, W_H2);
			5'd5:  u = mk(N_D1,  1'b0, N_E2X, 1'b1, 1'b0, 1'b1, W_H2);
			5'd6:  u = mk(N_S1,  1'b0, N_E1Z, 1'b0, 1'b1, 1'b0, W_Q0);
			5'd7:  u = mk(N_S2,  1'b0, N_E1Y, 1'b1, 1'b0, 1'b1, W_Q0);
			5'd8:  u = mk(N_S2,  1'b0, N_E1X, 1'b0, 1'b1, 1'b0, W_Q1);
			5'd9:  u = mk(N_S0,  1'b0, N_E1Z, 1'b1, 1'b0, 1'b1, W_Q1);
			5'd10: u = mk(N_S0,  1'b0, N_E1Y, 1'b0, 1'b1, 1'b0, W_Q2);
			5'd11: u = mk(N_S1,  1'b0, N_E1X, 1'b1, 1'b0, 1'b1, W_Q2);
			5'd12: u = mk(N_E1X, 1'b1, W_H0,  1'b0, 1'b1, 1'b0, W_A);
			5'd13: u = mk(N_E1Y, 1'b1, W_H1,  1'b0, 1'b0, 1'b0, W_A);
			5'd14: u = mk(N_E1Z, 1'b1, W_H2,  1'b0, 1'b0, 1'b1, W_A);
			5'd15: u = mk(N_S0,  1'b1, W_H0,  1'b0, 1'b1, 1'b0, W_SH);
			5'd16: u = mk(N_S1,  1'b1, W_H1,  1'b0, 1'b0, 1'b0, W_SH);
			5'd17: u = mk(N_S2,  1'b1, W_H2,  1'b0, 1'b0, 1'b1, W_SH);
			5'd18: u = mk(N_D0,  1'b1, W_Q0,  1'b0, 1'b1, 1'b0, W_DQ);
			5'd19: u = mk(N_D1,  1'b1, W_Q1,  1'b0, 1'b0, 1'b0, W_DQ);
			5'd20: u = mk(N_D2,  1'b1, W_Q2,  1'b0, 1'b0, 1'b1, W_DQ);
			5'd21: u = mk(N_E2X, 1'b1, W_Q0,  1'b0, 1'b1, 1'b0, W_EQ);
			5'd22: u = mk(N_E2Y, 1'b1, W_Q1,  1'b0, 1'b0, 1'b0, W_EQ);
			5'd23: u = mk(N_E2Z, 1'b1, W_Q2,  1'b0, 1'b0, 1'b1, W_EQ);
			default: u = mk(N_D0, 1'b0, N_D0, 1'b0, 1'b1, 1'b1, W_H0);
		endcase
		return u;
	endfunction

endpackage

@@ design/nrth_mac.sv @@
// nrth_mac: bit-serial signed multiply-accumulate, one multiplier bit a cycle
// depends on nrth_pkg
`timescale 1ns / 1ps
module nrth_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nrth_pkg::nrth_mac_ctl_t       ctl,
	input  logic [nrth_pkg::DIFF_W-1:0]   x,
	input  logic [nrth_pkg::ACC_W-1:0]    y,
	output logic [nrth_pkg::ACC_W-1:0]    acc,
	output logic                          done
);
	import nrth_pkg::*;

	localparam int CNT_W = $clog2(DIFF_W);

	logic [DIFF_W-1:0] xsh_q;
	logic [ACC_W-1:0]  ycur_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              sub;
	logic              msb;

	// top multiplier bit carries negative weight
	assign msb  = (cnt_q == CNT_W'(DIFF_W - 1));
	assign sub  = neg_q ^ msb;
	assign done = msb;
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (ctl.load) begin
			cnt_q <= '0;
			neg_q <= ctl.neg;
		end else if (!msb) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			xsh_q  <= x;
			ycur_q <= y;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end else begin
			if (xsh_q[0]) begin
				acc_q <= sub ? (acc_q - ycur_q) : (acc_q + ycur_q);
			end
			xsh_q  <= xsh_q >> 1;
			ycur_q <= ycur_q << 1;
		end
	end

endmodule

@@ design/nrth_div.sv @@
// nrth_div: restoring divider, one quotient bit a cycle, saturated to 32 bits
// depends on nrth_pkg
`timescale 1ns / 1ps
module nrth_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nrth_pkg::ACC_W-1:0]   num,
	input  logic [nrth_pkg::ACC_W-1:0]   den,
	output logic [nrth_pkg::DIST_W-1:0]  quo,
	output logic                         done
);
	import nrth_pkg::*;

	localparam int CNT_W = $clog2(ACC_W);

	logic [ACC_W:0]    rem_q;
	logic [ACC_W-1:0]  nsh_q;
	logic [ACC_W-1:0]  quo_q;
	logic [ACC_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [ACC_W:0]    trial;
	logic              fits;

	assign trial = {rem_q[ACC_W-1:0], nsh_q[ACC_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = busy_q && (cnt_q == CNT_W'(ACC_W - 1));
	assign quo   = (|quo_q[ACC_W-1:DIST_W]) ? '1 : quo_q[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nsh_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			nsh_q <= nsh_q << 1;
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

endmodule

@@ design/nearest_ray_triangle_hit.sv @@
// nearest_ray_triangle_hit: ray registers, product sequencer and nearest-hit tracking
// depends on nrth_pkg, nrth_mac, nrth_div
//
//   port group              dir   payload
//   in_valid/in_stall       in    in_word   (nrth_in_t, one triangle)
//   out_valid/out_stall     out   out_word  (nrth_out_t, after the last triangle)
//   wr_en/wr_index/wr_data  in    register write
//
// one triangle runs through 24 products on the single bit-serial multiply-
// accumulate unit, 10 write-backs, two check states, a divide and an update;
// a miss skips the divide
// in_stall is high from acceptance until the update is done, and after a last
// triangle until the output register is free; a finished word waits in the
// output register while the next triangle is taken
// reset clears control, best distance to all ones, ray origin 0, direction (0,0,256)
`timescale 1ns / 1ps
module nearest_ray_triangle_hit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  nrth_pkg::nrth_in_t           in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output nrth_pkg::nrth_out_t          out_word,
	input  logic                         wr_en,
	input  logic [nrth_pkg::REG_W-1:0]   wr_index,
	input  logic [nrth_pkg::DIST_W-1:0]  wr_data
);
	import nrth_pkg::*;

	nrth_state_t state_q, state_d;

	logic signed [COORD_W-1:0] coord_q [6];
	logic [DIST_W-1:0]         start_q;
	logic [DIST_W-1:0]         best_q;
	logic                      any_q;
	logic [DIFF_W-1:0]         nar_q [NUM_NAR];
	logic [ACC_W-1:0]          wreg_q [NUM_WIDE];
	logic [ACC_W-1:0]          sum_q;
	logic                      a_neg_q;
	logic                      ok_q;
	logic                      last_q;
	logic [STEP_W-1:0]         step_q;
	logic                      out_valid_q;
	nrth_out_t                 out_word_q;

	nrth_uop_t                 uop;
	nrth_mac_ctl_t             mac_ctl;
	logic [DIFF_W-1:0]         mac_x;
	logic [ACC_W-1:0]          mac_y;
	logic [ACC_W-1:0]          acc;
	logic                      mac_done;
	logic                      div_start;
	logic [DIST_W-1:0]         quo;
	logic                      div_done;
	logic                      accept;
	logic                      emit;
	logic [ACC_W-1:0]          num;
	logic                      ok1;
	logic                      ok2;

	function automatic logic [DIFF_W-1:0] dif(input logic signed [COORD_W-1:0] p,
		input logic signed [COORD_W-1:0] r);
		return {p[COORD_W-1], p} - {r[COORD_W-1], r};
	endfunction

	function automatic logic [DIFF_W-1:0] ext(input logic signed [COORD_W-1:0] p);
		return {p[COORD_W-1], p};
	endfunction

	assign accept    = in_valid && !in_stall;
	assign uop       = nrth_uop(step_q);
	assign mac_x     = nar_q[uop.xsel];
	assign mac_y     = uop.ywide ? wreg_q[uop.ysel]
		: {{(ACC_W - DIFF_W){nar_q[uop.ysel][DIFF_W-1]}}, nar_q[uop.ysel]};
	assign num       = wreg_q[W_EQ] << T_SHIFT;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// sign and range checks on u and v, then on u+v and t
	assign ok1 = !wreg_q[W_SH][ACC_W-1] && !wreg_q[W_DQ][ACC_W-1]
		&& !($signed(wreg_q[W_A]) < $signed(wreg_q[W_SH])) && (|wreg_q[W_A]);
	assign ok2 = ok_q && !($signed(wreg_q[W_A]) < $signed(sum_q))
		&& ($signed(wreg_q[W_A]) < $signed(num));

	nrth_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x      (mac_x),
		.y      (mac_y),
		.acc    (acc),
		.done   (mac_done)
	);

	nrth_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (wreg_q[W_A]),
		.quo    (quo),
		.done   (div_done)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (mac_done) state_d = uop.last ? ST_WB : ST_LOAD;
			end
			ST_WB:   state_d = (step_q == STEP_END) ? ST_CHK1 : ST_LOAD;
			ST_CHK1: state_d = ST_CHK2;
			ST_CHK2: state_d = ok2 ? ST_DIV : ST_UPD;
			ST_DIV:  if (div_done) state_d = ST_UPD;
			ST_UPD:  state_d = last_q ? ST_OUT : ST_IDLE;
			ST_OUT:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		mac_ctl.load  = (state_q == ST_LOAD);
		mac_ctl.clear = uop.first;
		mac_ctl.neg   = uop.neg ^ (a_neg_q && (step_q >= STEP_FLIP));
		div_start     = (state_q == ST_CHK2) && ok2;
		emit          = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			best_q      <= '1;
			any_q       <= 1'b0;
			start_q     <= '1;
			a_neg_q     <= 1'b0;
			ok_q        <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				coord_q[i] <= (i == int'(REG_DIRECTION_Z)) ? COORD_W'(256) : '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				if (wr_index < REG_START_RANGE) begin
					coord_q[wr_index] <= wr_data[COORD_W-1:0];
				end else if (wr_index == REG_START_RANGE) begin
					start_q <= wr_data;
				end
			end
			if (accept) begin
				step_q <= '0;
				last_q <= in_word.last_of_query;
				a_neg_q <= 1'b0;
				if (in_word.first_of_query) begin
					best_q <= start_q;
					any_q  <= 1'b0;
				end
			end
			if ((state_q == ST_MUL) && mac_done && !uop.last) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (state_q == ST_WB) begin
				if (uop.dest == W_A) begin
					a_neg_q <= acc[ACC_W-1];
				end
				if (step_q != STEP_END) begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (state_q == ST_CHK1) begin
				ok_q <= ok1;
			end
			if (state_q == ST_CHK2) begin
				ok_q <= ok2;
			end
			if ((state_q == ST_UPD) && ok_q && (quo < best_q)) begin
				best_q <= quo;
				any_q  <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			nar_q[N_D0]  <= ext(coord_q[REG_DIRECTION_X]);
			nar_q[N_D1]  <= ext(coord_q[REG_DIRECTION_Y]);
			nar_q[N_D2]  <= ext(coord_q[REG_DIRECTION_Z]);
			nar_q[N_E1X] <= dif(in_word.vertex1_x, in_word.vertex0_x);
			nar_q[N_E1Y] <= dif(in_word.vertex1_y, in_word.vertex0_y);
			nar_q[N_E1Z] <= dif(in_word.vertex1_z, in_word.vertex0_z);
			nar_q[N_E2X] <= dif(in_word.vertex2_x, in_word.vertex0_x);
			nar_q[N_E2Y] <= dif(in_word.vertex2_y, in_word.vertex0_y);
			nar_q[N_E2Z] <= dif(in_word.vertex2_z, in_word.vertex0_z);
			nar_q[N_S0]  <= dif(coord_q[REG_ORIGIN_X], in_word.vertex0_x);
			nar_q[N_S1]  <= dif(coord_q[REG_ORIGIN_Y], in_word.vertex0_y);
			nar_q[N_S2]  <= dif(coord_q[REG_ORIGIN_Z], in_word.vertex0_z);
		end
		if (state_q == ST_WB) begin
			// a is kept as its magnitude, later sums follow its sign
			if ((uop.dest == W_A) && acc[ACC_W-1]) begin
				wreg_q[uop.dest] <= '0 - acc;
			end else begin
				wreg_q[uop.dest] <= acc;
			end
		end
		if (state_q == ST_CHK1) begin
			sum_q <= wreg_q[W_SH] + wreg_q[W_DQ];
		end
		if (emit) begin
			out_word_q.nearest_distance <= best_q;
			out_word_q.hit_found        <= any_q;
		end
	end

endmodule
